FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define HSBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define HSBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/hsbd_pkg.sv
// Types and constants of the SECDED byte stream decoder.
`default_nettype none
package hsbd_pkg;

  localparam int BLOCK_BITS_DEF = 64;
  localparam int ENTRY_BITS     = 64;
  localparam int QDEPTH         = 4;
  localparam int QPTRW          = 2;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       record_end;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       uncorrectable;
    logic       last_of_run;
  } out_t;

  // Decoded bit stream of one codeword, first bit at the MSB.
  typedef struct packed {
    logic [ENTRY_BITS-1:0] bits;
    logic [3:0]            nbytes;
    logic                  bad_first;
    logic                  bad_rest;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/hsbd_front.sv
// Front end: codeword assembly, SECDED decode and data bit packing.
`default_nettype none
`include "assert_macros.svh"
module hsbd_front #(
  parameter int BLOCK_BITS = hsbd_pkg::BLOCK_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire hsbd_pkg::in_t  item,
  output logic                push,
  output hsbd_pkg::entry_t    entry
);

  localparam int BB   = BLOCK_BITS;
  localparam int CNTW = $clog2(BB);
  localparam int SUMW = $clog2(BB + 8);
  localparam int SYNW = $clog2(BB);
  localparam int D    = BB - 1 - $clog2(BB);
  localparam int SW   = D + 7;
  localparam int TW   = $clog2(SW + 1);
  localparam int ENTRY_BITS = hsbd_pkg::ENTRY_BITS;

  logic [BB-1:0]   cw_r, cw_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [6:0]      pbyte_r, pbyte_nxt;
  logic [2:0]      pcnt_r, pcnt_nxt;
  logic            pbad_r, pbad_nxt;

  logic [BB+7:0]   comb;
  logic [SUMW-1:0] sum;
  logic            complete;
  logic [BB-1:0]   cw;
  logic [SYNW-1:0] syn, flip;
  logic            par, bad;
  logic [D-1:0]    dvec;
  logic [SW-1:0]   pstream, psh;
  logic [TW-1:0]   total;
  logic [2:0]      new_pc;
  logic [6:0]      pmask;

  assign comb     = {8'b0, cw_r} | ((BB + 8)'(item.coded_byte) << cnt_r);
  assign sum      = SUMW'(cnt_r) + SUMW'(8);
  assign complete = sum >= SUMW'(BB);
  assign cw       = comb[BB-1:0];

  always_comb begin
    int j;
    syn  = '0;
    flip = '0;
    bad  = 1'b0;
    dvec = '0;
    j    = 0;
    par  = ^cw;
    for (int p = 1; p < BB; p++) begin
      if (cw[p-1]) syn = syn ^ SYNW'(p);
    end
    if (par) begin
      if (syn != '0) begin
        if ({1'b0, syn} < (SYNW + 1)'(BB)) flip = syn;
        else bad = 1'b1;
      end
    end else if (syn != '0) begin
      bad = 1'b1;
    end
    for (int p = 1; p < BB; p++) begin
      if ((p & (p - 1)) != 0) begin
        dvec[D-1-j] = cw[p-1] ^ (flip == SYNW'(p));
        j++;
      end
    end
  end

  assign pstream = ({dvec, 7'b0} >> pcnt_r) | (SW'(pbyte_r) << (SW - int'(pcnt_r)));
  assign total   = TW'(pcnt_r) + TW'(D);
  assign new_pc  = total[2:0];
  assign psh     = pstream >> (3'd7 - pcnt_r);
  assign pmask   = 7'h7f >> (3'd7 - new_pc);

  assign push             = accept && complete;
  assign entry.bits       = ENTRY_BITS'(pstream) << (hsbd_pkg::ENTRY_BITS - SW);
  assign entry.nbytes     = 4'(total >> 3);
  assign entry.bad_first  = pbad_r | bad;
  assign entry.bad_rest   = bad;

  always_comb begin
    cw_nxt    = cw_r;
    cnt_nxt   = cnt_r;
    pbyte_nxt = pbyte_r;
    pcnt_nxt  = pcnt_r;
    pbad_nxt  = pbad_r;
    if (accept) begin
      if (complete) begin
        cw_nxt    = BB'(comb[BB+7:BB]);
        cnt_nxt   = CNTW'(sum - SUMW'(BB));
        pbyte_nxt = psh[6:0] & pmask;
        pcnt_nxt  = new_pc;
        pbad_nxt  = (new_pc != 3'd0) && bad;
      end else begin
        cw_nxt  = cw;
        cnt_nxt = CNTW'(sum);
      end
      if (item.record_end) begin
        cw_nxt    = '0;
        cnt_nxt   = '0;
        pbyte_nxt = '0;
        pcnt_nxt  = '0;
        pbad_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r    <= '0;
      cnt_r   <= '0;
      pbyte_r <= '0;
      pcnt_r  <= '0;
      pbad_r  <= 1'b0;
    end else begin
      cw_r    <= cw_nxt;
      cnt_r   <= cnt_nxt;
      pbyte_r <= pbyte_nxt;
      pcnt_r  <= pcnt_nxt;
      pbad_r  <= pbad_nxt;
    end
  end

  `HSBD_ASSERT(a_cnt_range, {1'b0, cnt_r} < (CNTW + 1)'(BB), "codeword bit count out of range")
  `HSBD_ASSERT(a_push_bytes, push |-> (entry.nbytes != 4'd0), "decoded codeword yields no byte")
  `HSBD_ASSERT(a_rec_clear, (accept && item.record_end) |=> (pcnt_r == 3'd0 && cnt_r == '0),
               "record end left partial state")

endmodule
`default_nettype wire

FILE: rtl/core/hsbd_fifo.sv
// Decoded codeword queue between front and back end.
`default_nettype none
`include "assert_macros.svh"
module hsbd_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hsbd_pkg::entry_t  wdata,
  input  wire logic              pop,
  output hsbd_pkg::entry_t       head,
  output logic                   full,
  output logic                   empty
);

  localparam int QPTRW = hsbd_pkg::QPTRW;

  hsbd_pkg::entry_t                 mem_r [hsbd_pkg::QDEPTH];
  logic [hsbd_pkg::QPTRW-1:0]       wptr_r, wptr_nxt;
  logic [hsbd_pkg::QPTRW-1:0]       rptr_r, rptr_nxt;
  logic [hsbd_pkg::QPTRW:0]         cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full    = cnt_r == (hsbd_pkg::QPTRW + 1)'(hsbd_pkg::QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (hsbd_pkg::QPTRW + 1)'(do_push) - (hsbd_pkg::QPTRW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `HSBD_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `HSBD_ASSERT(a_ptr_track, (QPTRW'(wptr_r - rptr_r)) == cnt_r[hsbd_pkg::QPTRW-1:0],
               "queue pointers disagree with count")

endmodule
`default_nettype wire

FILE: rtl/core/hsbd_back.sv
// Back end: emits the bytes of each decoded codeword, one per transaction.
`default_nettype none
`include "assert_macros.svh"
module hsbd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hsbd_pkg::entry_t  head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output hsbd_pkg::out_t         out_item
);

  logic [2:0]                      bi_r, bi_nxt;
  logic [hsbd_pkg::ENTRY_BITS-1:0] shifted;
  logic                            last;
  logic                            take;

  assign shifted   = head.bits << {bi_r, 3'b000};
  assign last      = {1'b0, bi_r} == (head.nbytes - 4'd1);
  assign out_empty = q_empty;
  assign take      = out_pop && !q_empty;
  assign q_pop     = take && last;

  assign out_item.data_byte     = shifted[hsbd_pkg::ENTRY_BITS-1 -: 8];
  assign out_item.uncorrectable = (bi_r == 3'd0) ? head.bad_first : head.bad_rest;
  assign out_item.last_of_run   = last;

  always_comb begin
    bi_nxt = bi_r;
    if (take) bi_nxt = last ? 3'd0 : bi_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bi_r <= '0;
    end else begin
      bi_r <= bi_nxt;
    end
  end

  `HSBD_ASSERT(a_last_wraps, (take && last) |=> (bi_r == 3'd0), "byte index not rewound")
  `HSBD_ASSERT(a_idx_bound, !q_empty |-> ({1'b0, bi_r} < head.nbytes),
               "byte index beyond codeword bytes")

endmodule
`default_nettype wire

FILE: rtl/core/hamming_secded_byte_stream_decoder_unit.sv
// Top level of the extended Hamming SECDED byte stream decoder.
// Input channel: in_item (coded_byte, record_end) is taken when in_push is
//   high and in_full is low. Bytes fill BLOCK_BITS-bit codewords, LSB first.
// Result channel: out_item (data_byte, uncorrectable, last_of_run) is valid
//   while out_empty is low and is taken when out_pop is high.
// Results: only a byte that completes a codeword gives results.
// Throughput: one input byte per cycle while in_full is low; the front end
//   decodes a whole codeword in the accepting cycle. The back end emits one
//   byte per cycle while out_pop is high and the queue holds a codeword, up
//   to eight per codeword, from a four-entry codeword queue.
// in_full rises only when that queue holds four codewords not yet drained.
// Reset (rst_n low, synchronous) empties the queue and clears the partial
//   codeword and the partial output byte.
// A stalled receiver holds the current result on out_item; the front end keeps
//   taking bytes until the queue fills.
`default_nettype none
module hamming_secded_byte_stream_decoder_unit #(
  parameter int BLOCK_BITS = hsbd_pkg::BLOCK_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire hsbd_pkg::in_t   in_item,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output hsbd_pkg::out_t       out_item
);

  logic             accept;
  logic             push;
  logic             q_pop;
  logic             q_empty;
  hsbd_pkg::entry_t entry;
  hsbd_pkg::entry_t head;

  assign accept = in_push && !in_full;

  hsbd_front #(
    .BLOCK_BITS(BLOCK_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_item),
    .push  (push),
    .entry (entry)
  );

  hsbd_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(entry),
    .pop  (q_pop),
    .head (head),
    .full (in_full),
    .empty(q_empty)
  );

  hsbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

FILE: dv/hamming_secded_byte_stream_decoder_unit_tb.sv
// Testbench for the SECDED byte stream decoder: encoded, corrupted and raw streams.
module hamming_secded_byte_stream_decoder_unit_tb;

  localparam int BLK       = 64;
  localparam int DATA_BITS = 57;
  localparam int CHECKS    = 6;

  typedef enum int {
    ERR_NONE,
    ERR_SINGLE,
    ERR_DOUBLE,
    ERR_TRIPLE
  } fault_t;

  logic           clk;
  logic           rst_n;
  logic           in_push;
  logic           in_full;
  hsbd_pkg::in_t  in_item;
  logic           out_empty;
  logic           out_pop;
  hsbd_pkg::out_t out_item;

  // decoder state mirror
  logic [BLK-1:0] cw_bits;
  int             cw_fill;
  logic [7:0]     acc_byte;
  int             acc_count;
  logic           acc_bad;

  hsbd_pkg::out_t expected_bytes[$];
  hsbd_pkg::out_t step_bytes[$];
  hsbd_pkg::out_t want;
  int   error_count;
  bit   quiet;
  int   stall_left;

  hamming_secded_byte_stream_decoder_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("ERROR @%0t: %s got %0h want %0h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  function automatic void clear_decoder();
    cw_bits = '0;
    cw_fill = 0;
    acc_byte = '0;
    acc_count = 0;
    acc_bad = 1'b0;
  endfunction

  function automatic void decode_codeword();
    int   syn;
    bit   par;
    int   flip;
    bit   bad;
    logic b;
    hsbd_pkg::out_t o;
    syn = 0;
    par = 1'b0;
    flip = 0;
    bad = 1'b0;
    for (int p = 1; p <= BLK; p++) begin
      if (cw_bits[p-1]) begin
        par = ~par;
        if (p < BLK) syn ^= p;
      end
    end
    if (par) begin
      if (syn != 0) begin
        if (syn < BLK) flip = syn;
        else bad = 1'b1;
      end
    end else if (syn != 0) begin
      bad = 1'b1;
    end
    for (int p = 1; p < BLK; p++) begin
      if ((p & (p - 1)) == 0) continue;
      b = cw_bits[p-1] ^ (p == flip);
      acc_byte = {acc_byte[6:0], b};
      acc_count++;
      acc_bad |= bad;
      if (acc_count == 8) begin
        o.data_byte = acc_byte;
        o.uncorrectable = acc_bad;
        o.last_of_run = 1'b0;
        step_bytes = {step_bytes, o};
        acc_byte = '0;
        acc_count = 0;
        acc_bad = 1'b0;
      end
    end
  endfunction

  function automatic void absorb_byte(hsbd_pkg::in_t it);
    step_bytes.delete();
    for (int k = 0; k < 8; k++) begin
      cw_bits[cw_fill] = it.coded_byte[k];
      cw_fill++;
      if (cw_fill == BLK) begin
        decode_codeword();
        cw_bits = '0;
        cw_fill = 0;
      end
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_of_run = 1'b1;
    foreach (step_bytes[i]) expected_bytes = {expected_bytes, step_bytes[i]};
    if (it.record_end) clear_decoder();
  endfunction

  // Result check first, then prediction, so nothing is matched in its own cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (!out_empty && out_pop) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected transaction, data_byte", out_item.data_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.data_byte !== want.data_byte)
            report_mismatch("data_byte", out_item.data_byte, want.data_byte);
          if (out_item.uncorrectable !== want.uncorrectable)
            report_mismatch("uncorrectable", out_item.uncorrectable, want.uncorrectable);
          if (out_item.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_item.last_of_run, want.last_of_run);
        end
      end
      if (in_push && !in_full) absorb_byte(in_item);
    end
  end

  initial begin
    out_pop = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic logic [BLK-1:0] encode_data(logic [DATA_BITS-1:0] data);
    logic [BLK-1:0] cw;
    int             syn;
    int             j;
    cw = '0;
    syn = 0;
    j = 0;
    for (int p = 1; p < BLK; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p-1] = data[DATA_BITS-1-j];
        j++;
        if (cw[p-1]) syn ^= p;
      end
    end
    for (int i = 0; i < CHECKS; i++) cw[(1 << i) - 1] = syn[i];
    cw[BLK-1] = ^cw[BLK-2:0];
    return cw;
  endfunction

  function automatic logic [BLK-1:0] corrupt(logic [BLK-1:0] cw, fault_t kind);
    logic [BLK-1:0] mask;
    int             n;
    int             pos;
    mask = '0;
    n = (kind == ERR_SINGLE) ? 1 : (kind == ERR_DOUBLE) ? 2 : (kind == ERR_TRIPLE) ? 3 : 0;
    while ($countones(mask) < n) begin
      if ($urandom_range(0, 3) == 0) pos = (1 << $urandom_range(0, CHECKS)) - 1;
      else pos = $urandom_range(0, BLK - 1);
      mask[pos] = 1'b1;
    end
    return cw ^ mask;
  endfunction

  // Called and left at a falling edge; in_push stays high until the next call or a drain.
  task automatic send_item(input hsbd_pkg::in_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic send_codeword(input logic [BLK-1:0] cw, input int rec_at);
    hsbd_pkg::in_t it;
    for (int k = 0; k < BLK / 8; k++) begin
      it.coded_byte = cw[8*k +: 8];
      it.record_end = (k == rec_at);
      send_item(it);
      if (k == rec_at) break;
    end
  endtask

  task automatic wait_for_drain();
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_clean_codeword();
    send_codeword(encode_data({DATA_BITS{1'b1}}), -1);
  endtask

  task automatic test_single_error();
    logic [BLK-1:0] cw;
    cw = encode_data('0);
    cw[10] = ~cw[10];
    send_codeword(cw, -1);
  endtask

  task automatic test_double_error();
    logic [BLK-1:0] cw;
    cw = encode_data(DATA_BITS'({DATA_BITS/2{2'b01}}));
    cw[2] = ~cw[2];
    cw[4] = ~cw[4];
    send_codeword(cw, -1);
  endtask

  task automatic test_record_end();
    hsbd_pkg::in_t it;
    it.coded_byte = 8'hFF;
    it.record_end = 1'b0;
    send_item(it);
    it.coded_byte = 8'h00;
    it.record_end = 1'b1;
    send_item(it);
  endtask

  task automatic test_noise_bytes(input int count);
    hsbd_pkg::in_t it;
    for (int i = 0; i < count; i++) begin
      it.coded_byte = 8'($urandom_range(0, 255));
      it.record_end = ($urandom_range(0, 9) == 0) || (i == count - 1);
      send_item(it);
    end
  endtask

  task automatic test_error_mix(input int count);
    logic [DATA_BITS-1:0] data;
    logic [BLK-1:0]       cw;
    fault_t               kind;
    int                   roll;
    int                   rec_at;
    for (int i = 0; i < count; i++) begin
      data = DATA_BITS'({$urandom, $urandom});
      roll = $urandom_range(0, 9);
      if (roll < 4) kind = ERR_NONE;
      else if (roll < 7) kind = ERR_SINGLE;
      else if (roll < 9) kind = ERR_DOUBLE;
      else kind = ERR_TRIPLE;
      cw = corrupt(encode_data(data), kind);
      rec_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, BLK / 8 - 1) : -1;
      send_codeword(cw, rec_at);
    end
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    clear_decoder();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_clean_codeword();
    test_single_error();
    test_double_error();
    test_record_end();
    wait_for_drain();
    test_noise_bytes(30);
    test_error_mix(30);
    wait_for_drain();
    quiet = 1'b1;
    test_error_mix(10);
    wait_for_drain();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("hamming_secded_byte_stream_decoder_unit: match");
    end else begin
      $display("hamming_secded_byte_stream_decoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("hamming_secded_byte_stream_decoder_unit: mismatch");
    $finish;
  end

endmodule
